// ----- design/lws_pkg.sv -----
// ----------------------------------------------------------------------------
// lws_pkg: shared constants and types for the latency window statistics block
// Window size, field widths, derived counter widths and the link types
// passed between the sorted cells.
// ----------------------------------------------------------------------------
package lws_pkg;

    localparam int WINDOW = 64;

    localparam int VAL_W   = 24;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SUM_W   = VAL_W + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int OCNT_W  = 7;
    localparam int LVL_W   = 2;
    localparam int CFG_IDX_W = 4;

    // percentile bookkeeping: p_idx = floor(count * PCT_NUM / PCT_DEN)
    localparam int PCT_NUM = 95;
    localparam int PCT_DEN = 100;
    localparam int PREM_W  = $clog2(PCT_DEN + PCT_NUM);

    // tap select tree: groups of eight cells
    localparam int GRP_SIZE = 8;
    localparam int N_GROUPS = (WINDOW + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W    = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;
    localparam int SEL_W    = GRP_W + 3;

    localparam logic [VAL_W-1:0] WARN_RESET = VAL_W'(1000);
    localparam logic [VAL_W-1:0] CRIT_RESET = VAL_W'(50000);

    localparam logic [CFG_IDX_W-1:0] REG_WARN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CRIT = CFG_IDX_W'(1);

    localparam logic [LVL_W-1:0] ALARM_NORMAL = LVL_W'(0);
    localparam logic [LVL_W-1:0] ALARM_WARN   = LVL_W'(1);
    localparam logic [LVL_W-1:0] ALARM_CRIT   = LVL_W'(2);

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] val;
    } cell_link_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] key;
    } chain_cmd_t;

endpackage

// ----- design/lws_ram.sv -----
// ----------------------------------------------------------------------------
// lws_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lws_cell.sv -----
// ----------------------------------------------------------------------------
// lws_cell: one slot of the sorted window
// Holds one sample; on delete it takes its right neighbor, on insert it
// takes the new key or its left neighbor.
// ----------------------------------------------------------------------------
module lws_cell import lws_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  chain_cmd_t cmd,
    input  cell_link_t left,
    input  logic       left_gt,
    input  cell_link_t right,
    input  logic       del_en,
    output cell_link_t link,
    output logic       gt,
    output logic       match
);

    logic             valid_reg;
    logic             valid_next;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    // empty slots sort above every sample
    assign gt    = !valid_reg || (val_reg > cmd.key);
    assign match = valid_reg && (val_reg == cmd.key);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        if (cmd.del && del_en)
        begin
            valid_next = right.valid;
            val_next   = right.val;
        end
        else if (cmd.ins && gt)
        begin
            if (!left_gt)
            begin
                valid_next = 1'b1;
                val_next   = cmd.key;
            end
            else
            begin
                valid_next = left.valid;
                val_next   = left.val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.valid = valid_reg;
    assign link.val   = val_reg;

endmodule

// ----- design/lws_chain.sv -----
// ----------------------------------------------------------------------------
// lws_chain: sorted window as a row of cells
// Keeps the window in ascending order, removes the evicted sample and
// inserts the new one, and reads one rank through a two-stage tap tree.
// ----------------------------------------------------------------------------
module lws_chain import lws_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  chain_cmd_t       cmd,
    input  logic [IDX_W-1:0] tap_idx,
    output logic [VAL_W-1:0] tap_q,
    output logic [VAL_W-1:0] min_val
);

    cell_link_t              links [WINDOW];
    logic [WINDOW-1:0]       gt_vec;
    logic [WINDOW-1:0]       match_vec;
    logic [WINDOW-1:0]       del_vec;

    logic [VAL_W-1:0]        vals_pad [N_GROUPS*GRP_SIZE];
    logic [VAL_W-1:0]        grp_reg  [2**GRP_W];
    logic [GRP_W-1:0]        hi_reg;
    logic [VAL_W-1:0]        tap_q_reg;
    logic [SEL_W-1:0]        sel;

    // a cell shifts down once the first match lies at or below it
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            del_vec[i] = |(match_vec & ({WINDOW{1'b1}} >> (WINDOW - 1 - i)));
        end
    end

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        cell_link_t left_l;
        cell_link_t right_l;
        logic       left_gt_l;

        if (i == 0)
        begin : g_first
            assign left_l    = '0;
            assign left_gt_l = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_l    = links[i-1];
            assign left_gt_l = gt_vec[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_last
            assign right_l = '0;
        end
        else
        begin : g_mid_r
            assign right_l = links[i+1];
        end

        lws_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .left    (left_l),
            .left_gt (left_gt_l),
            .right   (right_l),
            .del_en  (del_vec[i]),
            .link    (links[i]),
            .gt      (gt_vec[i]),
            .match   (match_vec[i])
        );
    end

    assign min_val = links[0].val;

    always_comb
    begin
        for (int k = 0; k < N_GROUPS * GRP_SIZE; k++)
        begin
            vals_pad[k] = '0;
        end
        for (int k = 0; k < WINDOW; k++)
        begin
            vals_pad[k] = links[k].val;
        end
    end

    assign sel = SEL_W'(tap_idx);

    // stage one picks within each group of eight, stage two picks the group
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2**GRP_W; g++)
        begin
            if (g < N_GROUPS)
            begin
                grp_reg[g] <= vals_pad[g*GRP_SIZE + int'(sel[2:0])];
            end
            else
            begin
                grp_reg[g] <= '0;
            end
        end
        hi_reg    <= sel[SEL_W-1:3];
        tap_q_reg <= grp_reg[hi_reg];
    end

    assign tap_q = tap_q_reg;

endmodule

// ----- design/lws_div.sv -----
// ----------------------------------------------------------------------------
// lws_div: bit-serial restoring divider
// Divides the window sum by the sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lws_div import lws_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dvs_reg;

    logic [CNT_W:0]    shifted;
    logic              fits;
    logic [CNT_W:0]    diff;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/latency_window_stats_p95_top.sv -----
// ----------------------------------------------------------------------------
// latency_window_stats_p95_top: sliding window latency statistics
// Ring of recent samples, sorted cell row, mean divider and alarm grading.
// ----------------------------------------------------------------------------
// Each accepted latency sample passes the ring read, the sorted row update
// and the mean divider before its result is offered; the bit-serial divider,
// one quotient bit per cycle over the 31-bit window sum, is the longest step.
// The ring is read when a sample is accepted, then the evicted sample is
// removed from the sorted row and the new one inserted, and the maximum and
// 95th percentile are read from the sorted row while the divider runs. A new
// sample is taken once the previous one has finished its work, even while
// its result still waits in the output register. Configuration writes are
// taken in any cycle and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module latency_window_stats_p95_top import lws_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [VAL_W-1:0]     latency,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VAL_W-1:0]     window_min,
    output logic [VAL_W-1:0]     window_max,
    output logic [VAL_W-1:0]     window_mean,
    output logic [VAL_W-1:0]     window_p95,
    output logic [OCNT_W-1:0]    sample_count,
    output logic [LVL_W-1:0]     alarm_level,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_INS  = 4'd2;
    localparam logic [3:0] ST_TAP0 = 4'd3;
    localparam logic [3:0] ST_TAP1 = 4'd4;
    localparam logic [3:0] ST_TAP2 = 4'd5;
    localparam logic [3:0] ST_TAP3 = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;

    logic [VAL_W-1:0]  warn_reg;
    logic [VAL_W-1:0]  crit_reg;
    logic [IDX_W-1:0]  wpos_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic [PREM_W-1:0] prem_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  lat_reg;
    logic [VAL_W-1:0]  max_reg;
    logic [VAL_W-1:0]  p95_reg;

    logic              out_valid_reg;
    logic [VAL_W-1:0]  min_out_reg;
    logic [VAL_W-1:0]  max_out_reg;
    logic [VAL_W-1:0]  mean_out_reg;
    logic [VAL_W-1:0]  p95_out_reg;
    logic [OCNT_W-1:0] count_out_reg;
    logic [LVL_W-1:0]  alarm_out_reg;

    logic              in_xfer;
    logic              full;
    logic              out_free;
    logic [VAL_W-1:0]  ring_q;
    chain_cmd_t        cmd;
    logic [IDX_W-1:0]  tap_idx;
    logic [VAL_W-1:0]  tap_q;
    logic [VAL_W-1:0]  min_val;
    logic              div_done;
    logic [SUM_W-1:0]  div_q;
    logic [PREM_W-1:0] prem_sum;
    logic [LVL_W-1:0]  level;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign full      = (count_reg == CNT_W'(WINDOW));
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    lws_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (wpos_reg),
        .wdata (lat_reg),
        .re    (in_xfer),
        .raddr (wpos_reg),
        .rdata (ring_q)
    );

    always_comb
    begin
        cmd = '0;
        if (state_reg == ST_RD)
        begin
            cmd.del = full;
            cmd.key = ring_q;
        end
        else if (state_reg == ST_INS)
        begin
            cmd.ins = 1'b1;
            cmd.key = lat_reg;
        end
    end

    // max rank first, percentile rank in the following state
    assign tap_idx = (state_reg == ST_TAP0) ? IDX_W'(count_reg - CNT_W'(1)) : pidx_reg;

    lws_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .tap_idx (tap_idx),
        .tap_q   (tap_q),
        .min_val (min_val)
    );

    lws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_TAP0),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prem_sum = prem_reg + PREM_W'(PCT_NUM);

    always_comb
    begin
        if (lat_reg >= crit_reg)
        begin
            level = ALARM_CRIT;
        end
        else if (lat_reg >= warn_reg)
        begin
            level = ALARM_WARN;
        end
        else
        begin
            level = ALARM_NORMAL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:   state_next = ST_INS;
            ST_INS:  state_next = ST_TAP0;
            ST_TAP0: state_next = ST_TAP1;
            ST_TAP1: state_next = ST_TAP2;
            ST_TAP2: state_next = ST_TAP3;
            ST_TAP3: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            warn_reg      <= WARN_RESET;
            crit_reg      <= CRIT_RESET;
            wpos_reg      <= '0;
            count_reg     <= '0;
            pidx_reg      <= '0;
            prem_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WARN)
                begin
                    warn_reg <= cfg_data;
                end
                else if (cfg_index == REG_CRIT)
                begin
                    crit_reg <= cfg_data;
                end
            end

            if (state_reg == ST_RD)
            begin
                if (wpos_reg == IDX_W'(WINDOW - 1))
                begin
                    wpos_reg <= '0;
                end
                else
                begin
                    wpos_reg <= wpos_reg + IDX_W'(1);
                end
                // evicted sample leaves the running sum
                if (full)
                begin
                    sum_reg <= sum_reg - SUM_W'(ring_q);
                end
            end

            if (state_reg == ST_INS)
            begin
                sum_reg <= sum_reg + SUM_W'(lat_reg);
                if (!full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    // percentile rank grows by at most one per new sample
                    if (prem_sum >= PREM_W'(PCT_DEN))
                    begin
                        prem_reg <= prem_sum - PREM_W'(PCT_DEN);
                        pidx_reg <= pidx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        prem_reg <= prem_sum;
                    end
                end
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lat_reg <= latency;
        end
        if (state_reg == ST_TAP2)
        begin
            max_reg <= tap_q;
        end
        if (state_reg == ST_TAP3)
        begin
            p95_reg <= tap_q;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            min_out_reg   <= min_val;
            max_out_reg   <= max_reg;
            mean_out_reg  <= div_q[VAL_W-1:0];
            p95_out_reg   <= p95_reg;
            count_out_reg <= OCNT_W'(count_reg);
            alarm_out_reg <= level;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_min   = min_out_reg;
    assign window_max   = max_out_reg;
    assign window_mean  = mean_out_reg;
    assign window_p95   = p95_out_reg;
    assign sample_count = count_out_reg;
    assign alarm_level  = alarm_out_reg;

endmodule
